// ===== design/mdt_pkg.sv =====
// shared types, constants and helpers for the multi-character delimiter tokenizer
`timescale 1ns / 1ps

package mdt_pkg;

    // field and register widths
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 4;
    localparam int DELIM_BYTES     = 8;
    localparam int DCHARS_W        = CHAR_W * DELIM_BYTES;
    localparam int TLEN_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = DCHARS_W;
    localparam int MAX_DELIM_DEF   = 8;

    // register reset values
    localparam logic [LEN_W-1:0]  DELIM_LENGTH_RST = '0;
    localparam logic [TLEN_W-1:0] MAX_TOKEN_RST    = 8'd255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_LENGTH = 2'd0,
        REG_DELIM_CHARS  = 2'd1,
        REG_MAX_TOKEN    = 2'd2
    } cfg_reg_t;

    // where the tokenizer stands within the string
    typedef enum logic [1:0] {
        PH_LEAD    = 2'd0,
        PH_TOKEN   = 2'd1,
        PH_BETWEEN = 2'd2
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic [CHAR_W-1:0] token_char;
        logic              char_valid;
        logic              token_end;
        logic              last_of_run;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic search;
        logic flush;
        logic close;
        logic drain;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic loop_done;
        logic buf_empty;
        logic search_ok;
        logic flush_ok;
        logic close_ok;
        logic drain_ok;
        logic pend_valid;
        logic end_seen;
    } dp_status_t;

    // pick delimiter character idx out of the packed register
    function automatic logic [CHAR_W-1:0] delim_byte(
        input logic [DCHARS_W-1:0] chars,
        input logic [2:0]          idx
    );
        delim_byte = chars[CHAR_W*idx +: CHAR_W];
    endfunction

endpackage

// ===== design/mdt_char_if.sv =====
// character input channel
`timescale 1ns / 1ps

interface mdt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       string_end;

    modport source (output valid, output char_in, output string_end, input ready);
    modport sink   (input valid, input char_in, input string_end, output ready);
endinterface

// ===== design/mdt_token_if.sv =====
// token result channel
`timescale 1ns / 1ps

interface mdt_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_char;
    logic       char_valid;
    logic       token_end;
    logic       last_of_run;

    modport source (output valid, output token_char, output char_valid,
                    output token_end, output last_of_run, input ready);
    modport sink   (input valid, input token_char, input char_valid,
                    input token_end, input last_of_run, output ready);
endinterface

// ===== design/mdt_ctrl.sv =====
// sequencing state machine of the tokenizer
`timescale 1ns / 1ps

module mdt_ctrl
    import mdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_FLUSH = 5'b00100,
        S_CLOSE = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (status.loop_done)
                begin
                    if (status.end_seen)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (status.pend_valid)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (status.search_ok)
                begin
                    cmd.search = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (status.buf_empty)
                begin
                    state_next = S_CLOSE;
                end
                else if (status.flush_ok)
                begin
                    cmd.flush = 1'b1;
                end
            end
            S_CLOSE:
            begin
                if (status.close_ok)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.drain_ok)
                begin
                    cmd.drain  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== design/mdt_datapath.sv =====
// held characters, match search, token state and result registers
`timescale 1ns / 1ps

module mdt_datapath
    import mdt_pkg::*;
#(
    parameter int MAX_DELIM = MAX_DELIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CHAR_W-1:0]     char_in,
    input  logic                  string_end,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_res
);

    localparam int DEPTH = MAX_DELIM + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // configuration registers
    logic [LEN_W-1:0]    delim_length_reg;
    logic [DCHARS_W-1:0] delim_chars_reg;
    logic [TLEN_W-1:0]   max_token_reg;

    // search state
    logic [CHAR_W-1:0] work_reg  [DEPTH];
    logic [CHAR_W-1:0] work_next [DEPTH];
    logic [CHAR_W-1:0] work_sh   [DEPTH];
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [TLEN_W-1:0] tl_reg, tl_next;
    phase_t            phase_reg, phase_next;
    logic              open_reg, open_next;
    logic              end_reg, end_next;

    // result staging
    result_t pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]  d_sat;
    logic [CHAR_W-1:0] cur_char;
    logic [CNT_W-1:0]  k_inc;
    logic [CNT_W-1:0]  shift_amt;
    logic              hit;
    logic              hit_full;
    logic              tl_room;
    logic              search_emit;
    logic              close_emit;
    logic              slot_ok;
    logic              out_free;
    logic              emit;
    result_t           new_res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_length_reg <= DELIM_LENGTH_RST;
            delim_chars_reg  <= '0;
            max_token_reg    <= MAX_TOKEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELIM_LENGTH: delim_length_reg <= cfg_data[LEN_W-1:0];
                REG_DELIM_CHARS:  delim_chars_reg  <= cfg_data[DCHARS_W-1:0];
                REG_MAX_TOKEN:    max_token_reg    <= cfg_data[TLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // compare of the character at the match offset
    assign d_sat     = (delim_length_reg > LEN_W'(MAX_DELIM)) ? LEN_W'(MAX_DELIM)
                                                                : delim_length_reg;
    assign cur_char  = work_reg[k_reg[IDX_W-1:0]];
    assign k_inc     = k_reg + 1'b1;
    assign hit       = (d_sat != '0) && (cur_char == delim_byte(delim_chars_reg, 3'(k_reg)));
    assign hit_full  = hit && (LEN_W'(k_inc) == d_sat);
    assign tl_room   = (tl_reg < max_token_reg);
    assign shift_amt = (cmd.search && hit_full) ? CNT_W'(d_sat) : CNT_W'(1);

    // whether a step would produce a result, and room for it
    assign search_emit = hit ? (hit_full && (phase_reg == PH_TOKEN)) : tl_room;
    assign close_emit  = open_reg || (phase_reg == PH_LEAD);
    assign out_free    = !out_valid_reg || out_ready;
    assign slot_ok     = !pend_valid_reg || out_free;

    assign status.loop_done  = (k_reg == n_reg);
    assign status.buf_empty  = (n_reg == '0);
    assign status.search_ok  = !search_emit || slot_ok;
    assign status.flush_ok   = !tl_room || slot_ok;
    assign status.close_ok   = !close_emit || slot_ok;
    assign status.drain_ok   = pend_valid_reg && out_free;
    assign status.pend_valid = pend_valid_reg;
    assign status.end_seen   = end_reg;

    // held characters moved toward the front
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i + int'(shift_amt) < DEPTH)
            begin
                work_sh[i] = work_reg[IDX_W'(i + int'(shift_amt))];
            end
            else
            begin
                work_sh[i] = work_reg[i];
            end
        end
    end

    // one load, search, flush or close step
    always_comb
    begin
        work_next  = work_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        tl_next    = tl_reg;
        phase_next = phase_reg;
        open_next  = open_reg;
        end_next   = end_reg;
        emit       = 1'b0;
        new_res    = '0;

        if (cmd.load)
        begin
            work_next[n_reg[IDX_W-1:0]] = char_in;
            n_next   = n_reg + 1'b1;
            k_next   = '0;
            end_next = string_end;
        end

        if (cmd.search)
        begin
            if (hit)
            begin
                if (hit_full)
                begin
                    work_next = work_sh;
                    n_next    = n_reg - CNT_W'(d_sat);
                    k_next    = '0;
                    if (phase_reg == PH_TOKEN)
                    begin
                        emit              = 1'b1;
                        new_res.token_end = 1'b1;
                        tl_next           = '0;
                        open_next         = 1'b0;
                        phase_next        = PH_BETWEEN;
                    end
                end
                else
                begin
                    k_next = k_inc;
                end
            end
            else
            begin
                // oldest held character joins the token if there is room
                phase_next = PH_TOKEN;
                open_next  = 1'b1;
                if (tl_room)
                begin
                    emit               = 1'b1;
                    new_res.token_char = work_reg[0];
                    new_res.char_valid = 1'b1;
                    tl_next            = tl_reg + 1'b1;
                end
                work_next = work_sh;
                n_next    = n_reg - 1'b1;
                k_next    = '0;
            end
        end

        if (cmd.flush)
        begin
            phase_next = PH_TOKEN;
            open_next  = 1'b1;
            if (tl_room)
            begin
                emit               = 1'b1;
                new_res.token_char = work_reg[0];
                new_res.char_valid = 1'b1;
                tl_next            = tl_reg + 1'b1;
            end
            work_next = work_sh;
            n_next    = n_reg - 1'b1;
        end

        if (cmd.close)
        begin
            if (close_emit)
            begin
                emit              = 1'b1;
                new_res.token_end = 1'b1;
            end
            phase_next = PH_LEAD;
            n_next     = '0;
            k_next     = '0;
            tl_next    = '0;
            open_next  = 1'b0;
            end_next   = 1'b0;
        end
    end

    // pending result and output register
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_next             = pend_reg;
                out_next.last_of_run = 1'b0;
                out_valid_next       = 1'b1;
            end
            pend_next       = new_res;
            pend_valid_next = 1'b1;
        end
        else if (cmd.drain)
        begin
            out_next             = pend_reg;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            pend_valid_next      = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg          <= '0;
            k_reg          <= '0;
            tl_reg         <= '0;
            phase_reg      <= PH_LEAD;
            open_reg       <= 1'b0;
            end_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            n_reg          <= n_next;
            k_reg          <= k_next;
            tl_reg         <= tl_next;
            phase_reg      <= phase_next;
            open_reg       <= open_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// ===== design/multichar_delimiter_tokenizer.sv =====
// Splits a character stream into tokens at a multi-character delimiter.
// Steps: accept the character, search steps over the held characters (more after failed
// partial matches), end of the search; on string end a flush step per held character and a
// close step; then release of the pending result.
// Throughput: one character at a time; the shared compare step and output stalls set it.
// Reset (rst_n, asynchronous): registers to defaults, control idle; held chars undefined.
`timescale 1ns / 1ps

module multichar_delimiter_tokenizer
    import mdt_pkg::*;
#(
    parameter int MAX_DELIM = MAX_DELIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mdt_char_if.sink              chars,
    mdt_token_if.source           tokens
);

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    out_res;

    // sequencing
    mdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // search and result datapath
    mdt_datapath #(
        .MAX_DELIM (MAX_DELIM)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_in    (chars.char_in),
        .string_end (chars.string_end),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (tokens.valid),
        .out_ready  (tokens.ready),
        .out_res    (out_res)
    );

    // result fields onto the channel
    assign tokens.token_char  = out_res.token_char;
    assign tokens.char_valid  = out_res.char_valid;
    assign tokens.token_end   = out_res.token_end;
    assign tokens.last_of_run = out_res.last_of_run;

endmodule
